[rtl/dplt_pkg.sv]
package dplt_pkg;

   // Default sizes of the translator.
   localparam int DEF_PROCESSES     = 12;
   localparam int DEF_VIRTUAL_PAGES = 64;
   localparam int DEF_FRAME_SLOTS   = 9;
   localparam int DEF_OFFSET_BITS   = 8;

   // Fixed field widths of the request and response channels.
   localparam int PID_W      = 4;
   localparam int ADDR_W     = 14;
   localparam int SLOT_OUT_W = 4;
   localparam int OFF_OUT_W  = 8;
   localparam int EVP_OUT_W  = 6;
   localparam int FAULT_W    = 16;

   // Widest page number that the parameter ranges allow, and the width of a stamp.
   localparam int PAGE_MAX_W = 8;
   localparam int STAMP_W    = 8;

   // A seed stamp is capped at this bound; later pages at or above it never win.
   localparam logic [STAMP_W-1:0] STAMP_BOUND = 8'd200;

   // One step of the replacement search: a resident page and its stamp.
   typedef struct packed {
      logic                    valid;
      logic                    first;
      logic [SLOT_OUT_W-1:0]   slot;
      logic [PAGE_MAX_W-1:0]   page;
      logic [STAMP_W-1:0]      stamp;
   } dplt_step_type;

   // Current replacement victim.
   typedef struct packed {
      logic [SLOT_OUT_W-1:0]   slot;
      logic [PAGE_MAX_W-1:0]   page;
   } dplt_best_type;

endpackage

[rtl/dplt_if.sv]
// Request channel: one memory access.
interface dplt_req_if;
   logic                           valid;
   logic                           ready;
   logic [dplt_pkg::PID_W-1:0]     process_id;
   logic [dplt_pkg::ADDR_W-1:0]    virt_addr;

   modport source (output valid, output process_id, output virt_addr, input ready);
   modport sink   (input valid, input process_id, input virt_addr, output ready);
endinterface

// Response channel: translation result of one request.
interface dplt_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [dplt_pkg::SLOT_OUT_W-1:0]  frame_slot;
   logic [dplt_pkg::OFF_OUT_W-1:0]   page_offset;
   logic                             fault;
   logic                             evicted;
   logic [dplt_pkg::EVP_OUT_W-1:0]   evicted_page;
   logic [dplt_pkg::FAULT_W-1:0]     fault_total;

   modport source (output valid, output frame_slot, output page_offset, output fault,
                   output evicted, output evicted_page, output fault_total, input ready);
   modport sink   (input valid, input frame_slot, input page_offset, input fault,
                   input evicted, input evicted_page, input fault_total, output ready);
endinterface

[rtl/dplt_lru_search.sv]
// Shared compare unit of the replacement search. It sees one resident page
// per step and keeps the slot whose page carries the smallest stamp.
module dplt_lru_search (
   input  logic                    clock,
   input  dplt_pkg::dplt_step_type step_i,
   output dplt_pkg::dplt_best_type best_o
);

   dplt_pkg::dplt_best_type             best_ff, best_in;
   logic [dplt_pkg::STAMP_W-1:0]        best_stamp_ff, best_stamp_in;

   // The first step seeds the search with slot 0 and its stamp, capped at the bound; later steps
   // replace the victim only on a strictly smaller stamp, so ties stay low.
   always_comb begin
      best_in       = best_ff;
      best_stamp_in = best_stamp_ff;
      if (step_i.valid) begin
         if (step_i.first) begin
            best_in.slot  = step_i.slot;
            best_in.page  = step_i.page;
            best_stamp_in = (step_i.stamp < dplt_pkg::STAMP_BOUND) ?
                            step_i.stamp : dplt_pkg::STAMP_BOUND;
         end else if (step_i.stamp < best_stamp_ff) begin
            best_in.slot  = step_i.slot;
            best_in.page  = step_i.page;
            best_stamp_in = step_i.stamp;
         end
      end
   end

   always_ff @(posedge clock) begin
      best_ff       <= best_in;
      best_stamp_ff <= best_stamp_in;
   end

   assign best_o = best_ff;

endmodule

[rtl/demand_paging_lru_translator_unit.sv]
// Demand-paging translator with least-recently-used replacement. Each request
// names a process and a virtual address and returns the frame slot that holds
// the page, the offset, and fault and eviction information. The block works
// on one request at a time and is not ready while it does. A reciprocal
// multiply reduces the page number, then the page table and the per-process
// counters are read; a hit writes them back. A fault walks the process's
// frame slots through one shared compare unit, one slot per cycle, while the
// slot store and the page table are read in overlap, until it finds an empty
// slot or, with all slots full, picks a page to replace. After reset the
// block clears its stores in a pass over
// max(PROCESSES * VIRTUAL_PAGES, PROCESSES * FRAME_SLOTS) addresses before it
// accepts its first request. A finished response waits in an output register,
// and the next request is accepted while it does.
module demand_paging_lru_translator_unit #(
   parameter int PROCESSES     = dplt_pkg::DEF_PROCESSES,
   parameter int VIRTUAL_PAGES = dplt_pkg::DEF_VIRTUAL_PAGES,
   parameter int FRAME_SLOTS   = dplt_pkg::DEF_FRAME_SLOTS,
   parameter int OFFSET_BITS   = dplt_pkg::DEF_OFFSET_BITS
) (
   input logic        clock,
   input logic        reset,
   dplt_req_if.sink   req_ch,
   dplt_rsp_if.source rsp_ch
);

   // Sizes of the stores and widths derived from them.
   localparam int ENTRIES   = PROCESSES * VIRTUAL_PAGES;
   localparam int SLOTS     = PROCESSES * FRAME_SLOTS;
   localparam int EA_W      = $clog2(ENTRIES);
   localparam int SA_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int PA_W      = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
   localparam int PG_W      = $clog2(VIRTUAL_PAGES);
   localparam int SLOT_W    = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
   localparam int SC_W      = $clog2(FRAME_SLOTS + 1);
   localparam int CLEAR_LEN = (ENTRIES > SLOTS) ? ENTRIES : SLOTS;
   localparam int CL_W      = $clog2(CLEAR_LEN + 1);
   localparam int ADDR_W    = dplt_pkg::ADDR_W;
   localparam int PROD_W    = 2 * ADDR_W;
   localparam int STAMP_W   = dplt_pkg::STAMP_W;
   localparam int FAULT_W   = dplt_pkg::FAULT_W;
   localparam int SOW       = dplt_pkg::SLOT_OUT_W;
   localparam int OOW       = dplt_pkg::OFF_OUT_W;
   localparam int EOW       = dplt_pkg::EVP_OUT_W;
   localparam int PMW       = dplt_pkg::PAGE_MAX_W;

   // Reciprocal of the page count for the page-number reduction.
   localparam logic [ADDR_W-1:0] MOD_RECIP = ADDR_W'((1 << ADDR_W) / VIRTUAL_PAGES);
   localparam logic [ADDR_W-1:0] VP_A      = ADDR_W'(VIRTUAL_PAGES);
   localparam logic [OOW-1:0]    OFF_MASK  = (OFFSET_BITS >= OOW) ? {OOW{1'b1}} :
                                             OOW'((1 << OFFSET_BITS) - 1);

   // Sequencer states.
   localparam int ST_W = 4;
   localparam logic [ST_W-1:0] S_IDLE    = 4'd0;
   localparam logic [ST_W-1:0] S_MOD_MUL = 4'd1;
   localparam logic [ST_W-1:0] S_MOD_SUB = 4'd2;
   localparam logic [ST_W-1:0] S_MOD_FIX = 4'd3;
   localparam logic [ST_W-1:0] S_LOOK    = 4'd4;
   localparam logic [ST_W-1:0] S_HIT     = 4'd5;
   localparam logic [ST_W-1:0] S_SCAN    = 4'd6;
   localparam logic [ST_W-1:0] S_EVICT   = 4'd7;
   localparam logic [ST_W-1:0] S_FILL    = 4'd8;
   localparam logic [ST_W-1:0] S_NULL    = 4'd9;

   // Store words.
   typedef struct packed {
      logic                valid;
      logic [SLOT_W-1:0]   slot;
      logic [STAMP_W-1:0]  stamp;
   } ent_word_type;

   typedef struct packed {
      logic                occ;
      logic [PG_W-1:0]     page;
   } slot_word_type;

   typedef struct packed {
      logic [STAMP_W-1:0]  ctr;
      logic [FAULT_W-1:0]  fc;
   } proc_word_type;

   // Stores.
   ent_word_type  ent_mem  [ENTRIES];
   slot_word_type slot_mem [SLOTS];
   proc_word_type proc_mem [PROCESSES];

   ent_word_type  ent_q_ff;
   slot_word_type slot_q_ff;
   proc_word_type proc_q_ff;

   logic                ent_we, slot_we, proc_we;
   logic [EA_W-1:0]     ent_waddr, ent_raddr;
   logic [SA_W-1:0]     slot_waddr, slot_raddr;
   logic [PA_W-1:0]     proc_waddr, proc_raddr;
   ent_word_type        ent_wdata;
   slot_word_type       slot_wdata;
   proc_word_type       proc_wdata;

   // Control registers.
   logic [ST_W-1:0]     state_ff, state_in;
   logic                clear_ff, clear_in;
   logic [CL_W-1:0]     clr_ff, clr_in;
   logic [SC_W-1:0]     scan_ff, scan_in;
   logic                cmp_pend_ff, cmp_pend_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Request payload and working registers.
   logic [PA_W-1:0]     proc_ff, proc_in;
   logic [ADDR_W-1:0]   raw_ff, raw_in;
   logic [OOW-1:0]      offset_ff, offset_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [ADDR_W-1:0]   qd_ff, qd_in;
   logic [PG_W-1:0]     page_ff, page_in;
   logic [EA_W-1:0]     ent_base_ff, ent_base_in;
   logic [SA_W-1:0]     slot_base_ff, slot_base_in;
   logic [STAMP_W-1:0]  ctr_ff, ctr_in;
   logic [FAULT_W-1:0]  fc_ff, fc_in;
   logic [SLOT_W-1:0]   hit_slot_ff, hit_slot_in;
   logic [SLOT_W-1:0]   cmp_slot_ff, cmp_slot_in;
   logic [PG_W-1:0]     cmp_page_ff, cmp_page_in;
   logic [SLOT_W-1:0]   chosen_ff, chosen_in;
   logic [PG_W-1:0]     evict_page_ff, evict_page_in;
   logic                replace_ff, replace_in;

   // Response register.
   logic [SOW-1:0]      rsp_slot_ff, rsp_slot_in;
   logic [OOW-1:0]      rsp_off_ff, rsp_off_in;
   logic                rsp_fault_ff, rsp_fault_in;
   logic                rsp_evict_ff, rsp_evict_in;
   logic [EOW-1:0]      rsp_evp_ff, rsp_evp_in;
   logic [FAULT_W-1:0]  rsp_total_ff, rsp_total_in;
   logic                rsp_load;

   logic                req_accept, out_free;
   logic [ADDR_W-1:0]   rem, page_red;
   logic [SC_W-1:0]     scan_inc;

   dplt_pkg::dplt_step_type step;
   dplt_pkg::dplt_best_type best;

   assign req_ch.ready = (state_ff == S_IDLE) && !clear_ff;
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign scan_inc     = scan_ff + SC_W'(1);

   // Final correction of the page-number reduction: the estimated quotient
   // is low by at most one, so one compare and subtract finish it.
   assign rem      = raw_ff - qd_ff;
   assign page_red = (rem >= VP_A) ? (rem - VP_A) : rem;

   // One step per cycle into the compare unit while slots are walked.
   always_comb begin
      step       = '0;
      step.valid = (state_ff == S_SCAN) && cmp_pend_ff;
      step.first = (cmp_slot_ff == '0);
      step.slot  = SOW'(cmp_slot_ff);
      step.page  = PMW'(cmp_page_ff);
      step.stamp = ent_q_ff.stamp;
   end

   dplt_lru_search u_search (
      .clock  (clock),
      .step_i (step),
      .best_o (best)
   );

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      clear_in      = clear_ff;
      clr_in        = clr_ff;
      scan_in       = scan_ff;
      cmp_pend_in   = cmp_pend_ff;
      proc_in       = proc_ff;
      raw_in        = raw_ff;
      offset_in     = offset_ff;
      prod_in       = prod_ff;
      qd_in         = qd_ff;
      page_in       = page_ff;
      ent_base_in   = ent_base_ff;
      slot_base_in  = slot_base_ff;
      ctr_in        = ctr_ff;
      fc_in         = fc_ff;
      hit_slot_in   = hit_slot_ff;
      cmp_slot_in   = cmp_slot_ff;
      cmp_page_in   = cmp_page_ff;
      chosen_in     = chosen_ff;
      evict_page_in = evict_page_ff;
      replace_in    = replace_ff;

      rsp_load      = 1'b0;
      rsp_slot_in   = rsp_slot_ff;
      rsp_off_in    = rsp_off_ff;
      rsp_fault_in  = rsp_fault_ff;
      rsp_evict_in  = rsp_evict_ff;
      rsp_evp_in    = rsp_evp_ff;
      rsp_total_in  = rsp_total_ff;

      ent_we        = 1'b0;
      ent_waddr     = ent_base_ff + EA_W'(page_ff);
      ent_wdata     = '0;
      slot_we       = 1'b0;
      slot_waddr    = slot_base_ff + SA_W'(chosen_ff);
      slot_wdata    = '0;
      proc_we       = 1'b0;
      proc_waddr    = proc_ff;
      proc_wdata    = '0;
      ent_raddr     = ent_base_ff + EA_W'(page_ff);
      slot_raddr    = slot_base_ff;
      proc_raddr    = proc_ff;

      // Clearing pass after reset: zero every store word, one address per cycle.
      if (clear_ff) begin
         ent_we     = clr_ff < CL_W'(ENTRIES);
         ent_waddr  = clr_ff[EA_W-1:0];
         slot_we    = clr_ff < CL_W'(SLOTS);
         slot_waddr = clr_ff[SA_W-1:0];
         proc_we    = clr_ff < CL_W'(PROCESSES);
         proc_waddr = clr_ff[PA_W-1:0];
         clr_in     = clr_ff + CL_W'(1);
         if (clr_ff == CL_W'(CLEAR_LEN - 1)) begin
            clear_in = 1'b0;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               proc_in   = PA_W'(req_ch.process_id);
               raw_in    = ADDR_W'(req_ch.virt_addr >> OFFSET_BITS);
               offset_in = req_ch.virt_addr[OOW-1:0] & OFF_MASK;
               if (32'(req_ch.process_id) < PROCESSES) begin
                  state_in = S_MOD_MUL;
               end else begin
                  state_in = S_NULL;
               end
            end
         end

         // Estimate the quotient of the page number by the page count.
         S_MOD_MUL: begin
            prod_in      = PROD_W'(raw_ff) * PROD_W'(MOD_RECIP);
            ent_base_in  = EA_W'(32'(proc_ff) * VIRTUAL_PAGES);
            slot_base_in = SA_W'(32'(proc_ff) * FRAME_SLOTS);
            state_in     = S_MOD_SUB;
         end

         S_MOD_SUB: begin
            qd_in    = ADDR_W'(ADDR_W'(prod_ff >> ADDR_W) * VP_A);
            state_in = S_MOD_FIX;
         end

         // Page number is known; read its table entry and the counters.
         S_MOD_FIX: begin
            page_in   = PG_W'(page_red);
            ent_raddr = ent_base_ff + EA_W'(PG_W'(page_red));
            state_in  = S_LOOK;
         end

         S_LOOK: begin
            ctr_in      = proc_q_ff.ctr + STAMP_W'(1);
            hit_slot_in = ent_q_ff.slot;
            scan_in     = '0;
            cmp_pend_in = 1'b0;
            slot_raddr  = slot_base_ff;
            if (ent_q_ff.valid) begin
               fc_in    = proc_q_ff.fc;
               state_in = S_HIT;
            end else begin
               fc_in    = (proc_q_ff.fc == '1) ? proc_q_ff.fc : proc_q_ff.fc + FAULT_W'(1);
               state_in = S_SCAN;
            end
         end

         S_HIT: begin
            if (out_free) begin
               ent_we           = 1'b1;
               ent_wdata.valid  = 1'b1;
               ent_wdata.slot   = hit_slot_ff;
               ent_wdata.stamp  = ctr_ff;
               proc_we          = 1'b1;
               proc_wdata.ctr   = ctr_ff;
               proc_wdata.fc    = fc_ff;
               rsp_load         = 1'b1;
               rsp_slot_in      = SOW'(hit_slot_ff);
               rsp_off_in       = offset_ff;
               rsp_fault_in     = 1'b0;
               rsp_evict_in     = 1'b0;
               rsp_evp_in       = '0;
               rsp_total_in     = fc_ff;
               state_in         = S_IDLE;
            end
         end

         // Walk the slots: slot data for the current index arrives while the
         // stamp of the previous slot goes through the compare unit.
         S_SCAN: begin
            if (scan_ff != SC_W'(FRAME_SLOTS)) begin
               if (!slot_q_ff.occ) begin
                  chosen_in  = SLOT_W'(scan_ff);
                  replace_in = 1'b0;
                  state_in   = S_EVICT;
               end else begin
                  ent_raddr   = ent_base_ff + EA_W'(slot_q_ff.page);
                  slot_raddr  = slot_base_ff + SA_W'(scan_inc);
                  cmp_pend_in = 1'b1;
                  cmp_slot_in = SLOT_W'(scan_ff);
                  cmp_page_in = slot_q_ff.page;
                  scan_in     = scan_inc;
               end
            end else begin
               cmp_pend_in = 1'b0;
               if (!cmp_pend_ff) begin
                  chosen_in     = SLOT_W'(best.slot);
                  evict_page_in = PG_W'(best.page);
                  replace_in    = 1'b1;
                  state_in      = S_EVICT;
               end
            end
         end

         // Drop the old page's entry, if one is replaced, and give the slot to the new page.
         S_EVICT: begin
            if (replace_ff) begin
               ent_we    = 1'b1;
               ent_waddr = ent_base_ff + EA_W'(evict_page_ff);
               ent_wdata = '0;
            end
            slot_we         = 1'b1;
            slot_wdata.occ  = 1'b1;
            slot_wdata.page = page_ff;
            state_in        = S_FILL;
         end

         S_FILL: begin
            if (out_free) begin
               ent_we           = 1'b1;
               ent_wdata.valid  = 1'b1;
               ent_wdata.slot   = chosen_ff;
               ent_wdata.stamp  = ctr_ff;
               proc_we          = 1'b1;
               proc_wdata.ctr   = ctr_ff;
               proc_wdata.fc    = fc_ff;
               rsp_load         = 1'b1;
               rsp_slot_in      = SOW'(chosen_ff);
               rsp_off_in       = offset_ff;
               rsp_fault_in     = 1'b1;
               rsp_evict_in     = replace_ff;
               rsp_evp_in       = replace_ff ? EOW'(evict_page_ff) : '0;
               rsp_total_in     = fc_ff;
               state_in         = S_IDLE;
            end
         end

         // Unknown process: an all-zero response, no state touched.
         S_NULL: begin
            if (out_free) begin
               rsp_load     = 1'b1;
               rsp_slot_in  = '0;
               rsp_off_in   = '0;
               rsp_fault_in = 1'b0;
               rsp_evict_in = 1'b0;
               rsp_evp_in   = '0;
               rsp_total_in = '0;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ch.ready);
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         clear_ff     <= 1'b1;
         clr_ff       <= '0;
         scan_ff      <= '0;
         cmp_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_ff     <= clear_in;
         clr_ff       <= clr_in;
         scan_ff      <= scan_in;
         cmp_pend_ff  <= cmp_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and working registers.
   always_ff @(posedge clock) begin
      proc_ff       <= proc_in;
      raw_ff        <= raw_in;
      offset_ff     <= offset_in;
      prod_ff       <= prod_in;
      qd_ff         <= qd_in;
      page_ff       <= page_in;
      ent_base_ff   <= ent_base_in;
      slot_base_ff  <= slot_base_in;
      ctr_ff        <= ctr_in;
      fc_ff         <= fc_in;
      hit_slot_ff   <= hit_slot_in;
      cmp_slot_ff   <= cmp_slot_in;
      cmp_page_ff   <= cmp_page_in;
      chosen_ff     <= chosen_in;
      evict_page_ff <= evict_page_in;
      replace_ff    <= replace_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_off_ff    <= rsp_off_in;
      rsp_fault_ff  <= rsp_fault_in;
      rsp_evict_ff  <= rsp_evict_in;
      rsp_evp_ff    <= rsp_evp_in;
      rsp_total_ff  <= rsp_total_in;
   end

   // Page table store.
   always_ff @(posedge clock) begin
      if (ent_we) begin
         ent_mem[ent_waddr] <= ent_wdata;
      end
      ent_q_ff <= ent_mem[ent_raddr];
   end

   // Frame slot store.
   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_waddr] <= slot_wdata;
      end
      slot_q_ff <= slot_mem[slot_raddr];
   end

   // Per-process use and fault counters.
   always_ff @(posedge clock) begin
      if (proc_we) begin
         proc_mem[proc_waddr] <= proc_wdata;
      end
      proc_q_ff <= proc_mem[proc_raddr];
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.frame_slot   = rsp_slot_ff;
   assign rsp_ch.page_offset  = rsp_off_ff;
   assign rsp_ch.fault        = rsp_fault_ff;
   assign rsp_ch.evicted      = rsp_evict_ff;
   assign rsp_ch.evicted_page = rsp_evp_ff;
   assign rsp_ch.fault_total  = rsp_total_ff;

`ifndef ASSERT_OFF
   // A request keeps the block busy for at least the following cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_ch.ready)
      else $error("block ready right after accepting a request");

   // A hit never reports an eviction.
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.fault) |-> (!rsp_ch.evicted && rsp_ch.evicted_page == '0))
      else $error("eviction reported without a fault");

   // A fault response carries a nonzero fault total.
   a_fault_counted: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.fault) |-> (rsp_ch.fault_total != '0))
      else $error("fault response with zero fault total");

   // The slot walk never runs past the last slot.
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (scan_ff <= SC_W'(FRAME_SLOTS)))
      else $error("slot walk past the last slot");

   // Nothing is delivered while the stores are being cleared.
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      clear_ff |-> (!rsp_ch.valid && state_ff == S_IDLE))
      else $error("activity during the clearing pass");
`endif

endmodule
